// ===== hdl/fat12_pkg.sv =====
// Package for the FAT12 cluster chain step block.
// Holds the item and result structs, the controller/datapath command and status
// types, and the shared constants. It depends on nothing else.
package fat12_pkg;

  localparam int unsigned TableBytes = 8192;

  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIndexW-1:0] CfgDataStartLba = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgSectorsPerCluster = 8'd1;

  localparam logic [15:0] DataStartLbaReset = 16'd33;
  localparam logic [7:0] SectorsPerClusterReset = 8'd1;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqFollow = 1'b1;

  localparam logic [11:0] EntryMask = 12'hFFF;
  localparam logic [11:0] EndMark = 12'hFF8;
  localparam logic [11:0] FirstDataCluster = 12'd2;

  typedef struct packed {
    logic        req_type;
    logic [12:0] table_addr;
    logic [7:0]  table_byte;
    logic [11:0] cluster;
  } req_t;

  typedef struct packed {
    logic [31:0] sector_lba;
    logic [11:0] next_cluster;
    logic        chain_end;
    logic        bad_cluster;
  } res_t;

  typedef struct packed {
    logic latch;
    logic ram_we;
    logic mul_en;
    logic rd_hi;
    logic cap_lo;
    logic res_en;
    logic res_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic is_follow;
  } dp_sts_t;

endpackage

// ===== hdl/fat12_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the allocation table store; depends on nothing else.
module fat12_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fat12_ctrl.sv =====
// Controller state machine for the FAT12 cluster chain step block.
// Sequences loads and lookups through the datapath; uses fat12_pkg.
module fat12_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  input  fat12_pkg::dp_sts_t  sts_i,
  output fat12_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StRdHi,
    StFin
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StExec;
            busy_q  <= 1'b1;
          end
        end
        StExec: begin
          if (sts_i.is_follow) begin
            state_q <= StRdHi;
          end else begin
            state_q <= StIdle;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        StRdHi: begin
          state_q <= StFin;
        end
        StFin: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == StIdle) && accept;
    cmd_o.ram_we   = (state_q == StExec) && !sts_i.is_follow;
    cmd_o.mul_en   = (state_q == StExec);
    cmd_o.rd_hi    = (state_q == StRdHi);
    cmd_o.cap_lo   = (state_q == StRdHi);
    cmd_o.res_en   = ((state_q == StExec) && !sts_i.is_follow) || (state_q == StFin);
    cmd_o.res_zero = (state_q == StExec) && !sts_i.is_follow;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== hdl/fat12_dp.sv =====
// Datapath for the FAT12 cluster chain step block: item register, configuration
// registers, table RAM, sector multiply-add and entry unpacking.
// Uses fat12_pkg and instantiates fat12_ram.
module fat12_dp #(
  parameter int unsigned TableBytes = fat12_pkg::TableBytes
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fat12_pkg::req_t                      req_i,
  input  logic                                 cfg_we_i,
  input  logic [fat12_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [fat12_pkg::CfgDataW-1:0]       cfg_data_i,
  input  fat12_pkg::dp_cmd_t                   cmd_i,
  output fat12_pkg::dp_sts_t                   sts_o,
  output fat12_pkg::res_t                      res_o
);

  localparam int unsigned AddrW = $clog2(TableBytes);
  localparam logic [16:0] DepthLimit = 17'(TableBytes);

  fat12_pkg::req_t item_q;
  fat12_pkg::res_t res_q;
  logic [15:0]     data_start_q;
  logic [7:0]      spc_q;
  logic [19:0]     mul_q;
  logic [7:0]      lo_q;
  logic [7:0]      rdata;
  logic [12:0]     idx;
  logic [12:0]     rd_idx;
  logic [11:0]     cl_off;
  logic            wr_ok;
  logic [15:0]     word;
  logic [11:0]     next;
  logic            bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= fat12_pkg::DataStartLbaReset;
      spc_q        <= fat12_pkg::SectorsPerClusterReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == fat12_pkg::CfgDataStartLba) begin
        data_start_q <= cfg_data_i;
      end else if (cfg_index_i == fat12_pkg::CfgSectorsPerCluster) begin
        spc_q <= cfg_data_i[7:0];
      end
    end
  end

  assign idx    = 13'(item_q.cluster) + 13'(item_q.cluster[11:1]);
  assign rd_idx = cmd_i.rd_hi ? (idx + 13'd1) : idx;
  assign cl_off = item_q.cluster - fat12_pkg::FirstDataCluster;
  assign wr_ok  = (17'(item_q.table_addr) < DepthLimit);

  fat12_ram #(
    .Width(8),
    .Depth(TableBytes),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we && wr_ok),
    .waddr_i(AddrW'(item_q.table_addr)),
    .wdata_i(item_q.table_byte),
    .raddr_i(AddrW'(rd_idx)),
    .rdata_o(rdata)
  );

  assign word = {rdata, lo_q};
  assign next = item_q.cluster[0] ? word[15:4] : (word[11:0] & fat12_pkg::EntryMask);
  assign bad  = (item_q.cluster < fat12_pkg::FirstDataCluster);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= req_i;
    end
    if (cmd_i.mul_en) begin
      mul_q <= 20'(cl_off) * 20'(spc_q);
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata;
    end
    if (cmd_i.res_en) begin
      if (cmd_i.res_zero) begin
        res_q <= '0;
      end else begin
        res_q.sector_lba   <= bad ? 32'd0 : (32'(data_start_q) + 32'(mul_q));
        res_q.next_cluster <= next;
        res_q.chain_end    <= (next >= fat12_pkg::EndMark);
        res_q.bad_cluster  <= bad;
      end
    end
  end

  assign sts_o.is_follow = (item_q.req_type == fat12_pkg::ReqFollow);
  assign res_o = res_q;

endmodule

// ===== hdl/fat12_cluster_chain_step.sv =====
// Top level of the FAT12 cluster chain step block.
// Joins the controller (fat12_ctrl) and the datapath (fat12_dp); uses fat12_pkg.
//
// Usage:
// A transaction is accepted at a rising edge where start is high and busy is low.
// req_i.req_type selects a load (one allocation table byte written at table_addr)
// or a follow (lookup of cluster). Every transaction gives exactly one result on
// res_o, shown for one cycle with done_o high. A load returns an all-zero result.
// A follow returns the first sector of the cluster, the next cluster from the
// table, an end-of-chain flag and a bad-cluster flag.
// Sequence: a load passes through the StExec state before done_o rises, and a
// follow through StExec, StRdHi and StFin. Busy stays high until the result
// cycle, so a new transaction is accepted only once the previous result is out.
// The follow needs its extra states because of the single read port of the table
// RAM, which fetches the two entry bytes one after the other.
// The configuration channel (cfg_valid_i, cfg_ready_o) is always ready; write it
// only while busy is low and no result is pending.
// Reset restores the data start sector to 33 and the sectors per cluster to 1;
// the table contents are undefined until written. The receiver cannot stall.
module fat12_cluster_chain_step #(
  parameter int unsigned TableBytes = fat12_pkg::TableBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  fat12_pkg::req_t                 req_i,
  output logic                            done_o,
  output fat12_pkg::res_t                 res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fat12_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [fat12_pkg::CfgDataW-1:0]  cfg_data_i
);

  fat12_pkg::dp_cmd_t cmd;
  fat12_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fat12_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fat12_dp #(
    .TableBytes(TableBytes)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while a transaction is still in progress.");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("Accepted transaction did not raise busy.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");

  a_bad_zero_lba: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.bad_cluster) |-> (res_o.sector_lba == 32'd0))
    else $error("Bad cluster reported with a nonzero sector.");
`endif

endmodule
